[src/multi_task_heartbeat_watchdog_assert.svh]
// Assertion macros for the heartbeat watchdog. Define ASSERT_OFF to drop them.
`ifndef MULTI_TASK_HEARTBEAT_WATCHDOG_ASSERT_SVH
`define MULTI_TASK_HEARTBEAT_WATCHDOG_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define MTHW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("watchdog assertion failed");
// Next-cycle implication.
`define MTHW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("watchdog assertion failed");
`else
`define MTHW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MTHW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/mthw_pkg.sv]
package mthw_pkg;

    localparam int TASK_W    = 16;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 8;
    localparam int SEL_W     = 4;
    localparam int ACT_W     = 5;
    localparam int STAT_W    = 4;
    localparam int MODE_W    = 2;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_REGISTER  = 2'd0,
        REQ_HEARTBEAT = 2'd1,
        REQ_CHECK     = 2'd2,
        REQ_QUERY     = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        OP_IGNORE    = 3'd0,
        OP_REGISTER  = 3'd1,
        OP_HEARTBEAT = 3'd2,
        OP_CHECK     = 3'd3,
        OP_QUERY     = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 4'd0,
        ST_FULL      = 4'd1,
        ST_NOT_FOUND = 4'd2,
        ST_RESTART   = 4'd3,
        ST_LOG_ONLY  = 4'd4,
        ST_GIVE_UP   = 4'd5,
        ST_DONE      = 4'd6,
        ST_INACTIVE  = 4'd7,
        ST_IGNORED   = 4'd8
    } t_status;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE     = 2'd0,
        MODE_RECOVERY = 2'd1,
        MODE_SAFE     = 2'd2
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESTARTS = 2'd1;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;
    localparam logic [CNT_W-1:0]  RESTARTS_RESET = 8'd3;

    typedef struct packed {
        t_op               op;
        logic [TASK_W-1:0] task_id;
        logic              spec;
        logic [TIME_W-1:0] now;
        logic [SEL_W-1:0]  sel;
    } t_item;

    typedef struct packed {
        logic              last;
        t_status           status;
        logic [SEL_W-1:0]  slot_index;
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] hb;
        logic [CNT_W-1:0]  cnt;
        logic [ACT_W-1:0]  act;
        t_mode             mode;
    } t_result;

    typedef struct packed {
        logic [TIME_W-1:0] timeout;
        logic [CNT_W-1:0]  max_restarts;
    } t_cfg;

endpackage

[src/mthw_front.sv]
module mthw_front
    import mthw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [TASK_W-1:0] i_task_id,
    input  logic              i_has_restart_spec,
    input  logic [TIME_W-1:0] i_now_ticks,
    input  logic [SEL_W-1:0]  i_slot_select,
    output logic              o_q_valid,
    output t_item             o_q_item,
    input  logic              i_pop
);

    localparam int QDEPTH = 2;

    t_item      r_q [QDEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;

    // Classify: a zero id on register or heartbeat becomes an ignore, answered as ignored by the back end.
    always_comb begin
        w_item.task_id = i_task_id;
        w_item.spec    = i_has_restart_spec;
        w_item.now     = i_now_ticks;
        w_item.sel     = i_slot_select;
        case (t_req'(i_req_type))
            REQ_REGISTER:  w_item.op = (i_task_id == '0) ? OP_IGNORE : OP_REGISTER;
            REQ_HEARTBEAT: w_item.op = (i_task_id == '0) ? OP_IGNORE : OP_HEARTBEAT;
            REQ_CHECK:     w_item.op = OP_CHECK;
            REQ_QUERY:     w_item.op = OP_QUERY;
            default:       w_item.op = OP_IGNORE;
        endcase
    end

    assign o_stall   = (r_cnt == 2'(QDEPTH));
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

endmodule

[src/mthw_back.sv]
module mthw_back
    import mthw_pkg::*;
#(
    parameter int NUM_SLOTS = 12
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    input  t_item   i_q_item,
    output logic    o_pop,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_result
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    t_item  r_item;
    logic [IDX_W-1:0] r_idx;
    logic [ACT_W-1:0] r_act;
    logic    r_out_valid;
    t_result r_out;

    // Slot table
    logic [TASK_W-1:0] r_task [NUM_SLOTS];
    logic [TIME_W-1:0] r_hb   [NUM_SLOTS];
    logic [CNT_W-1:0]  r_att  [NUM_SLOTS];
    logic              r_rst  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_active;

    logic [IDX_W-1:0]  w_addr;
    logic [TASK_W-1:0] s_task;
    logic [TIME_W-1:0] s_hb;
    logic [CNT_W-1:0]  s_att;
    logic              s_act;
    logic              s_rst;
    logic              w_in_range;
    logic              w_end;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_hung;
    logic              w_retry;
    logic              w_out_free;
    logic              w_go;

    logic    w_emit;
    t_result w_res;
    logic    w_we_new;
    logic    w_we_hb;
    logic    w_inc_att;
    logic    w_kill;
    logic    w_finish;
    logic    w_to_done;
    logic    w_advance;
    logic    w_act_inc;

    assign w_addr     = (r_item.op == OP_QUERY) ? r_item.sel[IDX_W-1:0] : r_idx;
    assign w_in_range = ((SEL_W+1)'(r_item.sel) < (SEL_W+1)'(NUM_SLOTS));
    assign s_task     = r_task[w_addr];
    assign s_hb       = r_hb[w_addr];
    assign s_att      = r_att[w_addr];
    assign s_rst      = r_rst[w_addr];
    assign s_act      = r_active[w_addr];
    assign w_end      = (r_idx == IDX_W'(NUM_SLOTS - 1));
    assign w_elapsed  = r_item.now - s_hb;
    assign w_hung     = s_act && (w_elapsed > i_cfg.timeout);
    assign w_retry    = (s_att < i_cfg.max_restarts);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_go       = !w_emit || w_out_free;
    assign o_pop      = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        w_emit    = 1'b0;
        w_res     = '0;
        w_we_new  = 1'b0;
        w_we_hb   = 1'b0;
        w_inc_att = 1'b0;
        w_kill    = 1'b0;
        w_finish  = 1'b0;
        w_to_done = 1'b0;
        w_advance = 1'b0;
        w_act_inc = 1'b0;
        case (r_state)
            S_EXEC: begin
                case (r_item.op)
                    OP_IGNORE: begin
                        w_emit       = 1'b1;
                        w_res.status = ST_IGNORED;
                        w_res.last   = 1'b1;
                        w_finish     = 1'b1;
                    end
                    OP_QUERY: begin
                        w_emit           = 1'b1;
                        w_res.last       = 1'b1;
                        w_res.slot_index = r_item.sel;
                        w_finish         = 1'b1;
                        if (w_in_range && s_act) begin
                            w_res.status  = ST_OK;
                            w_res.task_id = s_task;
                            w_res.hb      = s_hb;
                            w_res.cnt     = s_att;
                        end else begin
                            w_res.status = ST_INACTIVE;
                        end
                    end
                    OP_REGISTER: begin
                        if (!s_act) begin
                            w_emit           = 1'b1;
                            w_we_new         = 1'b1;
                            w_res.last       = 1'b1;
                            w_res.status     = ST_OK;
                            w_res.slot_index = SEL_W'(r_idx);
                            w_res.task_id    = r_item.task_id;
                            w_res.hb         = r_item.now;
                            w_finish         = 1'b1;
                        end else if (w_end) begin
                            w_emit       = 1'b1;
                            w_res.last   = 1'b1;
                            w_res.status = ST_FULL;
                            w_finish     = 1'b1;
                        end else begin
                            w_advance = 1'b1;
                        end
                    end
                    OP_HEARTBEAT: begin
                        if (s_act && (s_task == r_item.task_id)) begin
                            w_emit           = 1'b1;
                            w_we_hb          = 1'b1;
                            w_res.last       = 1'b1;
                            w_res.status     = ST_OK;
                            w_res.slot_index = SEL_W'(r_idx);
                            w_res.task_id    = s_task;
                            w_res.hb         = r_item.now;
                            w_res.cnt        = s_att;
                            w_finish         = 1'b1;
                        end else if (w_end) begin
                            w_emit       = 1'b1;
                            w_res.last   = 1'b1;
                            w_res.status = ST_NOT_FOUND;
                            w_finish     = 1'b1;
                        end else begin
                            w_advance = 1'b1;
                        end
                    end
                    OP_CHECK: begin
                        w_res.slot_index = SEL_W'(r_idx);
                        w_res.task_id    = s_task;
                        if (w_hung && w_retry) begin
                            w_emit       = 1'b1;
                            w_we_hb      = 1'b1;
                            w_inc_att    = 1'b1;
                            w_act_inc    = 1'b1;
                            w_res.hb     = r_item.now;
                            w_res.cnt    = s_att + 1'b1;
                            w_res.status = s_rst ? ST_RESTART : ST_LOG_ONLY;
                            w_res.mode   = s_rst ? MODE_RECOVERY : MODE_NONE;
                        end else if (w_hung) begin
                            w_emit       = 1'b1;
                            w_kill       = 1'b1;
                            w_res.cnt    = s_att;
                            w_res.status = ST_GIVE_UP;
                            w_res.mode   = MODE_SAFE;
                        end else begin
                            w_act_inc = s_act;
                        end
                        w_to_done = w_end;
                        w_advance = !w_end;
                    end
                    default: begin
                        w_finish = 1'b1;
                    end
                endcase
            end
            S_DONE: begin
                w_emit       = 1'b1;
                w_res.last   = 1'b1;
                w_res.status = ST_DONE;
                w_res.act    = r_act;
                w_finish     = 1'b1;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_act       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (w_emit && w_go) || (r_out_valid && i_out_stall);
            if (w_emit && w_go) begin
                r_out <= w_res;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_item;
                        r_idx   <= '0;
                        r_act   <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_go) begin
                        if (w_finish) begin
                            r_state <= S_IDLE;
                        end else if (w_to_done) begin
                            r_state <= S_DONE;
                        end
                        if (w_advance) begin
                            r_idx <= IDX_W'(r_idx + 1'b1);
                        end
                        if (w_act_inc) begin
                            r_act <= ACT_W'(r_act + 1'b1);
                        end
                    end
                end
                S_DONE: begin
                    if (w_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Slot payload: written only at the walk index
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EXEC) && w_go) begin
            if (w_we_new) begin
                r_task[r_idx] <= r_item.task_id;
                r_hb[r_idx]   <= r_item.now;
                r_att[r_idx]  <= '0;
                r_rst[r_idx]  <= r_item.spec;
            end
            if (w_we_hb) begin
                r_hb[r_idx] <= r_item.now;
            end
            if (w_inc_att) begin
                r_att[r_idx] <= s_att + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if ((r_state == S_EXEC) && w_go) begin
            if (w_we_new) begin
                r_active[r_idx] <= 1'b1;
            end
            if (w_kill) begin
                r_active[r_idx] <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

[src/multi_task_heartbeat_watchdog.sv]
// Query and ignored requests give their result without a walk; register and
// heartbeat walk the slot table until they find their slot or reach its end.
// A check walks one slot per cycle while the result output is not stalled. The back end
// pops the next transaction only when done with the last; a two-entry input queue keeps
// taking transactions meanwhile. Reset (synchronous, active low) empties the queue, drops
// the output and marks every slot inactive; timeout returns to 1000 ticks, max restarts to 3.
module multi_task_heartbeat_watchdog
    import mthw_pkg::*;
#(
    parameter int NUM_SLOTS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [TASK_W-1:0]    i_task_id,
    input  logic                 i_has_restart_spec,
    input  logic [TIME_W-1:0]    i_now_ticks,
    input  logic [SEL_W-1:0]     i_slot_select,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_last,
    output logic [STAT_W-1:0]    o_status,
    output logic [SEL_W-1:0]     o_slot_index,
    output logic [TASK_W-1:0]    o_slot_task_id,
    output logic [TIME_W-1:0]    o_heartbeat_time,
    output logic [CNT_W-1:0]     o_restart_count,
    output logic [ACT_W-1:0]     o_active_count,
    output logic [MODE_W-1:0]    o_mode_request,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data
);

    logic [TIME_W-1:0] r_timeout;
    logic [CNT_W-1:0]  r_max_restarts;
    t_cfg              w_cfg;
    logic              w_q_valid;
    t_item             w_q_item;
    logic              w_pop;
    t_result           w_result;
    logic              w_res_give_up;
    logic              w_give_up_ok;
    logic              w_res_not_done;
    logic              w_res_done;
    logic              w_done_ok;

    // Configuration registers: writes are always taken; unknown indexes drop.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout      <= TIMEOUT_RESET;
            r_max_restarts <= RESTARTS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIMEOUT:      r_timeout      <= i_cfg_data;
                CFG_MAX_RESTARTS: r_max_restarts <= i_cfg_data[CNT_W-1:0];
                default: begin
                    r_timeout <= r_timeout;
                end
            endcase
        end
    end

    assign w_cfg.timeout      = r_timeout;
    assign w_cfg.max_restarts = r_max_restarts;

    // Front end: decode the request type and hold transactions in a short queue.
    mthw_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .o_stall            (o_in_stall),
        .i_req_type         (i_req_type),
        .i_task_id          (i_task_id),
        .i_has_restart_spec (i_has_restart_spec),
        .i_now_ticks        (i_now_ticks),
        .i_slot_select      (i_slot_select),
        .o_q_valid          (w_q_valid),
        .o_q_item           (w_q_item),
        .i_pop              (w_pop)
    );

    // Back end: walk the slot table, update it and emit results.
    mthw_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (w_result)
    );

    assign o_last           = w_result.last;
    assign o_status         = w_result.status;
    assign o_slot_index     = w_result.slot_index;
    assign o_slot_task_id   = w_result.task_id;
    assign o_heartbeat_time = w_result.hb;
    assign o_restart_count  = w_result.cnt;
    assign o_active_count   = w_result.act;
    assign o_mode_request   = w_result.mode;

    // Result classes watched by the assertions below.
    assign w_res_give_up  = o_out_valid && (o_status == ST_GIVE_UP);
    assign w_give_up_ok   = (o_mode_request == MODE_SAFE) && (o_heartbeat_time == '0);
    assign w_res_not_done = o_out_valid && (o_status != ST_DONE);
    assign w_res_done     = o_out_valid && (o_status == ST_DONE);
    assign w_done_ok      = o_last && (o_active_count <= ACT_W'(NUM_SLOTS));

`include "multi_task_heartbeat_watchdog_assert.svh"

    // Pop only from a non-empty queue.
    `MTHW_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, w_pop, w_q_valid)
    // A given-up slot asks for safe mode and reports no heartbeat.
    `MTHW_ASSERT_NOW(a_give_up_safe, i_clk, i_rst_n, w_res_give_up, w_give_up_ok)
    // Active count only rides on check done, which always closes the transaction.
    `MTHW_ASSERT_NOW(a_active_on_done, i_clk, i_rst_n, w_res_not_done, o_active_count == '0)
    `MTHW_ASSERT_NOW(a_done_last, i_clk, i_rst_n, w_res_done, w_done_ok)

endmodule
